>>> sv/lr_pkg.sv
// Shared definitions for the line rasterizer: command codes and result flags.
// No dependencies; used by lr_core and line_rasterizer.
`default_nettype none

package lr_pkg;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef struct packed {
      logic last_pixel;
      logic pixel_valid;
   } lr_flags_type;

endpackage

`default_nettype wire

>>> sv/lr_core.sv
// Bresenham line state and per-word pixel datapath.
// Depends on lr_pkg for command codes and the result flag struct.
`default_nettype none

module lr_core #(
   parameter int COORD_BITS = 12
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           load,
   input  wire                           cmd,
   input  wire  signed [COORD_BITS-1:0]  x_start,
   input  wire  signed [COORD_BITS-1:0]  y_start,
   input  wire  signed [COORD_BITS-1:0]  x_end,
   input  wire  signed [COORD_BITS-1:0]  y_end,
   output logic signed [COORD_BITS-1:0]  pixel_x,
   output logic signed [COORD_BITS-1:0]  pixel_y,
   output lr_pkg::lr_flags_type          flags
);

   localparam int DW = COORD_BITS + 1;   // delta and step count width
   localparam int EW = COORD_BITS + 3;   // error term width

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [EW-1:0]         err_ff, err_in;
   logic [DW-1:0]         major_ff, major_in;
   logic [DW-1:0]         minor_ff, minor_in;
   logic                  x_neg_ff, x_neg_in;
   logic                  y_neg_ff, y_neg_in;
   logic                  x_major_ff, x_major_in;
   logic [DW-1:0]         steps_ff, steps_in;
   logic                  active_ff, active_in;

   logic [DW-1:0]         dx, dy, adx, ady, s_major, s_minor;
   logic                  s_x_major;
   logic [EW-1:0]         err_init;
   logic                  minor_move;
   logic                  move_x, move_y;
   logic [COORD_BITS-1:0] step_x, step_y;
   logic [EW-1:0]         err_step;

   // start setup: deltas, major axis, first error term
   always_comb begin
      dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
      dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
      adx = dx[DW-1] ? (~dx + DW'(1)) : dx;
      ady = dy[DW-1] ? (~dy + DW'(1)) : dy;
      s_x_major = adx > ady;
      s_major = s_x_major ? adx : ady;
      s_minor = s_x_major ? ady : adx;
      err_init = {1'b0, s_minor, 1'b0} - {2'b00, s_major};
   end

   // one step along the major axis
   always_comb begin
      minor_move = !err_ff[EW-1] && (err_ff != '0);
      err_step = err_ff + {1'b0, minor_ff, 1'b0}
                 - (minor_move ? {1'b0, major_ff, 1'b0} : EW'(0));
      move_x = x_major_ff || minor_move;
      move_y = !x_major_ff || minor_move;
      step_x = !move_x ? cur_x_ff
             : (x_neg_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1));
      step_y = !move_y ? cur_y_ff
             : (y_neg_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1));
   end

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      err_in     = err_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      x_major_in = x_major_ff;
      steps_in   = steps_ff;
      active_in  = active_ff;
      pixel_x    = '0;
      pixel_y    = '0;
      flags      = '0;
      case (cmd)
         lr_pkg::CMD_START: begin
            cur_x_in   = x_start;
            cur_y_in   = y_start;
            err_in     = err_init;
            major_in   = s_major;
            minor_in   = s_minor;
            x_neg_in   = dx[DW-1];
            y_neg_in   = dy[DW-1];
            x_major_in = s_x_major;
            steps_in   = s_major;
            active_in  = s_major != '0;
            pixel_x    = x_start;
            pixel_y    = y_start;
            flags.last_pixel  = s_major == '0;
            flags.pixel_valid = 1'b1;
         end
         lr_pkg::CMD_STEP: begin
            // no line: drop the step, state holds
            if (active_ff) begin
               cur_x_in  = step_x;
               cur_y_in  = step_y;
               err_in    = err_step;
               steps_in  = steps_ff - DW'(1);
               active_in = steps_ff != DW'(1);
               pixel_x   = step_x;
               pixel_y   = step_y;
               flags.last_pixel  = steps_ff == DW'(1);
               flags.pixel_valid = 1'b1;
            end
         end
         default: begin
            flags = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         err_ff     <= '0;
         major_ff   <= '0;
         minor_ff   <= '0;
         x_neg_ff   <= 1'b0;
         y_neg_ff   <= 1'b0;
         x_major_ff <= 1'b0;
         steps_ff   <= '0;
         active_ff  <= 1'b0;
      end else if (load) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         err_ff     <= err_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         x_neg_ff   <= x_neg_in;
         y_neg_ff   <= y_neg_in;
         x_major_ff <= x_major_in;
         steps_ff   <= steps_in;
         active_ff  <= active_in;
      end
   end

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> steps_ff != '0)
      else $error("active line with no steps left");

   a_minor_le_major: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> minor_ff <= major_ff)
      else $error("minor delta exceeds major delta");

   a_idle_step_holds: assert property (@(posedge clock) disable iff (reset)
      load && cmd == lr_pkg::CMD_STEP && !active_ff
      |=> $stable(cur_x_ff) && $stable(cur_y_ff) && $stable(err_ff) && !active_ff)
      else $error("step with no line changed state");

endmodule

`default_nettype wire

>>> sv/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: handshake and result register.
// Depends on lr_pkg and lr_core.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, cmd, x/y_start, x/y_end | in
//   rsp     | rsp_valid/ready, pixel_x/y, last, valid  | out
//
// One word per cycle while no response is held waiting: each request word is
// resolved in the cycle it is taken, and its result lands in the response
// register on the next edge.
// Reset clears the line state and empties the response register.
// A low rsp_ready stalls the request side only while a response is waiting.
`default_nettype none

module line_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_cmd,
   input  wire  signed [COORD_BITS-1:0] req_x_start,
   input  wire  signed [COORD_BITS-1:0] req_y_start,
   input  wire  signed [COORD_BITS-1:0] req_x_end,
   input  wire  signed [COORD_BITS-1:0] req_y_end,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last_pixel,
   output logic                         rsp_pixel_valid
);

   logic                         accept;
   logic signed [COORD_BITS-1:0] core_x, core_y;
   lr_pkg::lr_flags_type         core_flags;

   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] pixel_x_ff;
   logic signed [COORD_BITS-1:0] pixel_y_ff;
   lr_pkg::lr_flags_type         flags_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lr_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .cmd     (req_cmd),
      .x_start (req_x_start),
      .y_start (req_y_start),
      .x_end   (req_x_end),
      .y_end   (req_y_end),
      .pixel_x (core_x),
      .pixel_y (core_y),
      .flags   (core_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_x_ff <= core_x;
         pixel_y_ff <= core_y;
         flags_ff   <= core_flags;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_last_pixel  = flags_ff.last_pixel;
   assign rsp_pixel_valid = flags_ff.pixel_valid;

   a_start_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == lr_pkg::CMD_START |=> rsp_valid_ff && flags_ff.pixel_valid)
      else $error("start word did not produce a pixel");

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flags_ff.last_pixel |-> flags_ff.pixel_valid)
      else $error("last flag on an invalid pixel");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !flags_ff.pixel_valid |-> pixel_x_ff == '0 && pixel_y_ff == '0)
      else $error("invalid pixel carries coordinates");

endmodule

`default_nettype wire
